>>> rtl/mks_pkg.sv
// Shared definitions for the matrix keypad scanner: geometry constants, event
// and register codes, reset values, the per-key state record and a saturating add.
// No dependencies.
package mks_pkg;

  localparam int ROWS             = 4;
  localparam int COLS             = 4;
  localparam int DEBOUNCE_SAMPLES = 4;
  localparam int NKEYS            = ROWS * COLS;
  localparam int ROW_W            = $clog2(ROWS);
  localparam int COL_W            = $clog2(COLS);
  localparam int KEY_W            = $clog2(NKEYS);

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;
  localparam logic [1:0] EV_REPEAT  = 2'd3;

  localparam logic [1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [1:0] CFG_REPEAT     = 2'd1;
  localparam logic [1:0] CFG_HOLD_STEP  = 2'd2;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [15:0] REPEAT_RESET     = 16'd200;
  localparam logic [7:0]  HOLD_STEP_RESET  = 8'd4;

  typedef struct packed {
    logic [DEBOUNCE_SAMPLES-1:0] hist;
    logic                        released;
    logic [15:0]                 hold;
    logic [15:0]                 thresh;
  } key_state_t;

  localparam key_state_t KEY_STATE_RESET = '{
    hist:     '1,
    released: 1'b1,
    hold:     16'd0,
    thresh:   LONG_PRESS_RESET
  };

  localparam int STATE_W = $bits(key_state_t);

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

>>> rtl/mks_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mks_key_logic.sv
// Per-key update: debounce history, press and release detection, hold time
// and long-press repeat threshold. Depends on mks_pkg.
module mks_key_logic (
  input  mks_pkg::key_state_t st,
  input  logic                level,
  input  logic [15:0]         long_press_ms,
  input  logic [15:0]         repeat_ms,
  input  logic [7:0]          hold_step_ms,
  output mks_pkg::key_state_t st_next,
  output logic [1:0]          ev
);

  logic [mks_pkg::DEBOUNCE_SAMPLES-1:0] h;

  always_comb begin
    h       = {st.hist[mks_pkg::DEBOUNCE_SAMPLES-2:0], level};
    st_next = st;
    st_next.hist = h;
    ev      = mks_pkg::EV_NONE;

    priority if (h == '1) begin
      if (!st.released) begin
        ev           = mks_pkg::EV_RELEASE;
        st_next.hold = 16'd0;
      end
      st_next.released = 1'b1;
    end else if (h == '0) begin
      if (st.released) begin
        ev           = mks_pkg::EV_PRESS;
        st_next.hold = 16'd0;
      end else begin
        st_next.hold = mks_pkg::sat_add16(st.hold, {8'd0, hold_step_ms});
      end
      st_next.released = 1'b0;
    end else begin
      st_next.released = st.released;
    end

    if (long_press_ms != 16'd0) begin
      if (st_next.hold >= long_press_ms) begin
        if (st_next.hold >= st.thresh) begin
          st_next.thresh = mks_pkg::sat_add16(st.thresh, repeat_ms);
          if (ev == mks_pkg::EV_NONE) begin
            ev = mks_pkg::EV_REPEAT;
          end
        end
      end else begin
        st_next.thresh = long_press_ms;
      end
    end
  end

endmodule

>>> rtl/matrix_keypad_scanner_core.sv
// Matrix keypad scanner core: one request per scan tick, one result per key of the row.
// The first result of a request passes the a and b stage registers into the output register.
// Throughput: one result per cycle while out_ready does not stall; a new request is taken as the
// row's last key advances, set by the one RAM read port, read and written back once per key.
// Reset is synchronous; per-key valid bits make untouched entries read as reset state at once.
// Depends on mks_pkg, mks_ram and mks_key_logic.
module matrix_keypad_scanner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  col_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  key_index,
  output logic [1:0]  event_kind,
  output logic [3:0]  row_drive,
  output logic        last
);

  logic [15:0] long_press_ms;
  logic [15:0] repeat_ms;
  logic [7:0]  hold_step_ms;

  logic [mks_pkg::ROW_W-1:0] row_index;
  logic [mks_pkg::ROW_W-1:0] row_next;
  logic [3:0]                drive_next;

  logic                      a_busy;
  logic [mks_pkg::ROW_W-1:0] a_row;
  logic [mks_pkg::COL_W-1:0] a_col;
  logic [3:0]                a_levels;
  logic [3:0]                a_drive;
  logic [mks_pkg::KEY_W-1:0] a_key;
  logic                      a_level;
  logic                      a_last;

  logic                      b_valid;
  logic [mks_pkg::KEY_W-1:0] b_key;
  logic                      b_level;
  logic                      b_last;
  logic [3:0]                b_drive;
  logic                      b_init;

  logic [mks_pkg::NKEYS-1:0] key_valid;

  logic                         adv;
  logic [mks_pkg::STATE_W-1:0]  ram_rdata;
  mks_pkg::key_state_t          st_cur;
  mks_pkg::key_state_t          st_next;
  logic [1:0]                   ev;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;

  assign row_next   = (row_index == mks_pkg::ROW_W'(mks_pkg::ROWS - 1)) ?
                      '0 : row_index + mks_pkg::ROW_W'(1);
  assign drive_next = (32'(row_next) < 4) ? ~(4'b0001 << row_next) : 4'hF;

  assign a_key   = mks_pkg::KEY_W'(mks_pkg::KEY_W'(a_row) * mks_pkg::KEY_W'(mks_pkg::COLS)
                   + mks_pkg::KEY_W'(a_col));
  assign a_level = (32'(a_col) < 4) ? a_levels[2'(a_col)] : 1'b0;
  assign a_last  = (a_col == mks_pkg::COL_W'(mks_pkg::COLS - 1));

  assign in_ready = !a_busy || (adv && a_last);

  mks_ram #(
    .WIDTH (mks_pkg::STATE_W),
    .DEPTH (mks_pkg::NKEYS)
  ) u_state_ram (
    .clk   (clk),
    .we    (adv && b_valid),
    .waddr (b_key),
    .wdata (st_next),
    .re    (adv && a_busy),
    .raddr (a_key),
    .rdata (ram_rdata)
  );

  assign st_cur = b_init ? mks_pkg::KEY_STATE_RESET : mks_pkg::key_state_t'(ram_rdata);

  mks_key_logic u_key_logic (
    .st            (st_cur),
    .level         (b_level),
    .long_press_ms (long_press_ms),
    .repeat_ms     (repeat_ms),
    .hold_step_ms  (hold_step_ms),
    .st_next       (st_next),
    .ev            (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= mks_pkg::LONG_PRESS_RESET;
      repeat_ms     <= mks_pkg::REPEAT_RESET;
      hold_step_ms  <= mks_pkg::HOLD_STEP_RESET;
      row_index     <= '0;
      a_busy        <= 1'b0;
      a_col         <= '0;
      b_valid       <= 1'b0;
      out_valid     <= 1'b0;
      key_valid     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mks_pkg::CFG_LONG_PRESS: long_press_ms <= cfg_data;
          mks_pkg::CFG_REPEAT:     repeat_ms     <= cfg_data;
          mks_pkg::CFG_HOLD_STEP:  hold_step_ms  <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        row_index <= row_next;
        a_busy    <= 1'b1;
        a_col     <= '0;
      end else if (adv && a_busy) begin
        if (a_last) begin
          a_busy <= 1'b0;
        end else begin
          a_col <= a_col + mks_pkg::COL_W'(1);
        end
      end

      if (adv) begin
        b_valid   <= a_busy;
        out_valid <= b_valid;
        if (b_valid) begin
          key_valid[b_key] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_row    <= row_index;
      a_levels <= col_levels;
      a_drive  <= drive_next;
    end
    if (adv && a_busy) begin
      b_key   <= a_key;
      b_level <= a_level;
      b_last  <= a_last;
      b_drive <= a_drive;
      b_init  <= !key_valid[a_key];
    end
    if (adv && b_valid) begin
      key_index  <= 4'(b_key);
      event_kind <= ev;
      row_drive  <= b_drive;
      last       <= b_last;
    end
  end

endmodule
